>>> rtl/core/pbsu_pkg.sv
package pbsu_pkg;

  // Opcode codes of the request
  localparam logic [2:0] OP_B     = 3'd0;
  localparam logic [2:0] OP_BC    = 3'd1;
  localparam logic [2:0] OP_BCCTR = 3'd2;
  localparam logic [2:0] OP_BCLR  = 3'd3;
  localparam logic [2:0] OP_MTSPR = 3'd4;
  localparam logic [2:0] OP_MFSPR = 3'd5;

  // Special register numbers after the halves of the field are swapped back
  localparam logic [9:0] SPR_XER = 10'd1;
  localparam logic [9:0] SPR_LR  = 10'd8;
  localparam logic [9:0] SPR_CTR = 10'd9;

  // BO bit positions
  localparam int unsigned BO_CTR_SENSE = 1;
  localparam int unsigned BO_SKIP_CTR  = 2;
  localparam int unsigned BO_CR_SENSE  = 3;
  localparam int unsigned BO_SKIP_CR   = 4;

  localparam logic [31:0] INSTR_BYTES = 32'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        instr_address;
    logic               absolute_flag;
    logic               link_flag;
    logic [4:0]         branch_options;
    logic [4:0]         cond_bit_index;
    logic signed [23:0] displacement_words;
    logic [31:0]        cond_register;
    logic [9:0]         spr_field;
    logic [63:0]        gpr_in;
  } req_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] next_address;
    logic [63:0] spr_read;
    logic        unsupported;
  } rsp_t;

  // Write controls from the execute logic to the special registers
  typedef struct packed {
    logic        lr_we;
    logic [63:0] lr_wd;
    logic        ctr_we;
    logic [63:0] ctr_wd;
    logic        xer_we;
    logic [63:0] xer_wd;
  } spr_wr_t;

endpackage

>>> rtl/core/pbsu_spr_file.sv
module pbsu_spr_file (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbsu_pkg::spr_wr_t wr_i,
  output logic [63:0]       lr_o,
  output logic [63:0]       ctr_o,
  output logic [63:0]       xer_o
);
  import pbsu_pkg::*;

  logic [63:0] lr_q, lr_d;
  logic [63:0] ctr_q, ctr_d;
  logic [63:0] xer_q, xer_d;

  // Take each write when its enable is set, hold otherwise
  always_comb begin
    lr_d  = wr_i.lr_we  ? wr_i.lr_wd  : lr_q;
    ctr_d = wr_i.ctr_we ? wr_i.ctr_wd : ctr_q;
    xer_d = wr_i.xer_we ? wr_i.xer_wd : xer_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= '0;
      ctr_q <= '0;
      xer_q <= '0;
    end else begin
      lr_q  <= lr_d;
      ctr_q <= ctr_d;
      xer_q <= xer_d;
    end
  end

  assign lr_o  = lr_q;
  assign ctr_o = ctr_q;
  assign xer_o = xer_q;

endmodule

>>> rtl/core/pbsu_exec.sv
module pbsu_exec (
  input  logic              fire_i,
  input  pbsu_pkg::req_t    req_i,
  input  logic [63:0]       lr_i,
  input  logic [63:0]       ctr_i,
  input  logic [63:0]       xer_i,
  output pbsu_pkg::rsp_t    rsp_o,
  output pbsu_pkg::spr_wr_t wr_o
);
  import pbsu_pkg::*;

  logic [31:0] fall;
  logic [31:0] disp_bytes;
  logic [31:0] rel_target;
  logic [9:0]  spr_num;
  logic [63:0] ctr_dec;
  logic        ctr_ok;
  logic        cr_ok;
  logic        is_branch;
  logic        taken;
  logic [31:0] target;
  logic [63:0] rd;
  logic        unsup;
  logic        lr_we_op, ctr_we_op, xer_we_op;
  logic [63:0] ctr_wd_op;

  // Address arithmetic
  assign fall       = req_i.instr_address + INSTR_BYTES;
  assign disp_bytes = {{6{req_i.displacement_words[23]}}, req_i.displacement_words, 2'b00};
  assign rel_target = (req_i.absolute_flag ? 32'd0 : req_i.instr_address) + disp_bytes;

  // Swap the SPR field halves back into a register number
  assign spr_num = {req_i.spr_field[4:0], req_i.spr_field[9:5]};

  // Count and condition tests
  assign ctr_dec = ctr_i - 64'd1;
  assign ctr_ok  = req_i.branch_options[BO_SKIP_CTR] ||
                   (req_i.branch_options[BO_CTR_SENSE] ? (ctr_dec == '0) : (ctr_dec != '0));
  assign cr_ok   = req_i.branch_options[BO_SKIP_CR] ||
                   (req_i.cond_register[req_i.cond_bit_index] ==
                    req_i.branch_options[BO_CR_SENSE]);

  assign is_branch = (req_i.opcode == OP_B) || (req_i.opcode == OP_BC) ||
                     (req_i.opcode == OP_BCCTR) || (req_i.opcode == OP_BCLR);

  // Decode and execute
  always_comb begin
    taken     = 1'b0;
    target    = fall;
    rd        = '0;
    unsup     = 1'b0;
    lr_we_op  = 1'b0;
    ctr_we_op = 1'b0;
    xer_we_op = 1'b0;
    ctr_wd_op = ctr_dec;
    case (req_i.opcode)
      OP_B: begin
        taken  = 1'b1;
        target = rel_target;
      end
      OP_BC: begin
        taken     = ctr_ok && cr_ok;
        target    = rel_target;
        ctr_we_op = !req_i.branch_options[BO_SKIP_CTR];
      end
      OP_BCCTR: begin
        taken  = cr_ok;
        target = {ctr_i[31:2], 2'b00};
      end
      OP_BCLR: begin
        taken     = ctr_ok && cr_ok;
        target    = {lr_i[31:2], 2'b00};
        ctr_we_op = !req_i.branch_options[BO_SKIP_CTR];
      end
      OP_MTSPR: begin
        case (spr_num)
          SPR_XER: xer_we_op = 1'b1;
          SPR_LR:  lr_we_op  = 1'b1;
          SPR_CTR: begin
            ctr_we_op = 1'b1;
            ctr_wd_op = req_i.gpr_in;
          end
          default: unsup = 1'b1;
        endcase
      end
      OP_MFSPR: begin
        case (spr_num)
          SPR_XER: rd = xer_i;
          SPR_LR:  rd = lr_i;
          SPR_CTR: rd = ctr_i;
          default: unsup = 1'b1;
        endcase
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  // Link write from a branch wins over nothing else: mtspr is never a branch
  always_comb begin
    wr_o        = '0;
    wr_o.xer_we = fire_i && xer_we_op;
    wr_o.xer_wd = req_i.gpr_in;
    wr_o.ctr_we = fire_i && ctr_we_op;
    wr_o.ctr_wd = ctr_wd_op;
    wr_o.lr_we  = fire_i && (lr_we_op || (is_branch && req_i.link_flag));
    wr_o.lr_wd  = lr_we_op ? req_i.gpr_in : {32'd0, fall};
  end

  assign rsp_o.taken        = taken;
  assign rsp_o.next_address = taken ? target : fall;
  assign rsp_o.spr_read     = rd;
  assign rsp_o.unsupported  = unsup;

endmodule

>>> rtl/core/ppc_branch_spr_unit.sv
// Channel | Valid       | Stall       | Payload
// --------+-------------+-------------+-------------------------
// input   | in_valid_i  | in_stall_o  | in_req_i  (pbsu_pkg::req_t)
// output  | out_valid_o | out_stall_i | out_rsp_o (pbsu_pkg::rsp_t)
//
// One request per cycle while in_stall_o is low. A request passes from the input
// register through the execute logic into the result register; the execute
// logic updates LR, CTR and XER in the same cycle it fills the result register.
// Reset clears LR, CTR and XER to zero and empties both pipeline registers.
// A stalled result holds in the result register while the input register still
// fills, so input stall rises only when both registers are occupied.
module ppc_branch_spr_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pbsu_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pbsu_pkg::rsp_t out_rsp_o
);
  import pbsu_pkg::*;

  logic    st_valid_q;
  req_t    req_q;
  logic    out_valid_q;
  rsp_t    rsp_q;
  logic    advance;
  rsp_t    rsp;
  spr_wr_t spr_wr;
  logic [63:0] lr, ctr, xer;

  // Move the held request on whenever the result register is free or draining
  assign advance    = st_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = st_valid_q && !advance;

  pbsu_spr_file u_spr_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (spr_wr),
    .lr_o   (lr),
    .ctr_o  (ctr),
    .xer_o  (xer)
  );

  pbsu_exec u_exec (
    .fire_i (advance),
    .req_i  (req_q),
    .lr_i   (lr),
    .ctr_i  (ctr),
    .xer_i  (xer),
    .rsp_o  (rsp),
    .wr_o   (spr_wr)
  );

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        st_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_no_taken_unsup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.taken && out_rsp_o.unsupported))
    else $error("taken and unsupported both set");

  a_read_not_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.spr_read != '0)) |-> !out_rsp_o.taken)
    else $error("SPR read data on a taken branch");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("executed request did not reach result register");

  a_held_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && !advance) |=> (st_valid_q && $stable(req_q)))
    else $error("held request lost or changed");
`endif

endmodule
